FILE: rtl/dcf_pkg.sv
`timescale 1ns / 1ps

package dcf_pkg;

  // x / 10 == (x * 205) >> 11 for every x below 1029
  localparam int unsigned BcdRecip = 205;
  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam int unsigned YearRecip = 5243;
  localparam int unsigned YearDiv = 100;
  localparam int unsigned SecPerMin = 60;

  localparam int unsigned FrameBits = 60;

  // raw fields as they arrive
  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic [3:0]  month_number;
    logic [13:0] full_year;
    logic        summer_time;
    logic [5:0]  second_index;
  } fields_t;

  // after the first stage: small fields coded, year quotient known
  typedef struct packed {
    logic [6:0]  min_bcd;
    logic [5:0]  hour_bcd;
    logic [5:0]  day_bcd;
    logic [2:0]  wday_bcd;
    logic [4:0]  mon_bcd;
    logic [13:0] year;
    logic [7:0]  year_q;
    logic        summer;
    logic [5:0]  sec;
  } stg1_t;

  // after the second stage: year reduced below one hundred
  typedef struct packed {
    logic [6:0] min_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [2:0] wday_bcd;
    logic [4:0] mon_bcd;
    logic [6:0] year_rem;
    logic       summer;
    logic [5:0] sec;
  } stg2_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame;
    logic [5:0]           sec;
  } stg3_t;

  // two BCD digits of a value below one hundred
  function automatic logic [7:0] bcd_small(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'(BcdRecip);
    q    = prod[14:11];
    r    = v - 7'(7'(q) * 7'd10);
    return {q, r[3:0]};
  endfunction

endpackage

FILE: rtl/dcf_split.sv
`timescale 1ns / 1ps

module dcf_split (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  dcf_pkg::fields_t in_fld,
  output logic             vld_r,
  output dcf_pkg::stg2_t   stg2_r
);

  logic           vld1_r;
  dcf_pkg::stg1_t stg1_r;
  dcf_pkg::stg1_t stg1_nxt;
  dcf_pkg::stg2_t stg2_nxt;

  logic [7:0]  min_code;
  logic [7:0]  hour_code;
  logic [7:0]  day_code;
  logic [7:0]  mon_code;
  logic [26:0] year_prod;
  logic [13:0] year_sub;
  logic [13:0] year_diff;

  // stage one: digit split of the small fields, year quotient by reciprocal, second index wrapped at 60
  always_comb begin
    min_code  = dcf_pkg::bcd_small({1'b0, in_fld.minute});
    hour_code = dcf_pkg::bcd_small({2'b0, in_fld.hour});
    day_code  = dcf_pkg::bcd_small({2'b0, in_fld.day_of_month});
    mon_code  = dcf_pkg::bcd_small({3'b0, in_fld.month_number});
    year_prod = 27'(in_fld.full_year) * 27'(dcf_pkg::YearRecip);

    stg1_nxt.min_bcd  = min_code[6:0];
    stg1_nxt.hour_bcd = hour_code[5:0];
    stg1_nxt.day_bcd  = day_code[5:0];
    stg1_nxt.wday_bcd = in_fld.day_of_week;
    stg1_nxt.mon_bcd  = mon_code[4:0];
    stg1_nxt.year     = in_fld.full_year;
    stg1_nxt.year_q   = year_prod[26:19];
    stg1_nxt.summer   = in_fld.summer_time;
    if (in_fld.second_index >= 6'(dcf_pkg::SecPerMin)) begin
      stg1_nxt.sec = in_fld.second_index - 6'(dcf_pkg::SecPerMin);
    end else begin
      stg1_nxt.sec = in_fld.second_index;
    end
  end

  // stage two: year remainder
  always_comb begin
    year_sub  = 14'(14'(stg1_r.year_q) * 14'(dcf_pkg::YearDiv));
    year_diff = stg1_r.year - year_sub;

    stg2_nxt.min_bcd  = stg1_r.min_bcd;
    stg2_nxt.hour_bcd = stg1_r.hour_bcd;
    stg2_nxt.day_bcd  = stg1_r.day_bcd;
    stg2_nxt.wday_bcd = stg1_r.wday_bcd;
    stg2_nxt.mon_bcd  = stg1_r.mon_bcd;
    stg2_nxt.year_rem = year_diff[6:0];
    stg2_nxt.summer   = stg1_r.summer;
    stg2_nxt.sec      = stg1_r.sec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld_r  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg1_r <= stg1_nxt;
      stg2_r <= stg2_nxt;
    end
  end

endmodule

FILE: rtl/dcf_frame.sv
`timescale 1ns / 1ps

module dcf_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  dcf_pkg::stg2_t in_stg,
  output logic           vld_r,
  output dcf_pkg::stg3_t stg3_r
);

  dcf_pkg::stg3_t stg3_nxt;
  logic [7:0]     year_bcd;
  logic           min_par;
  logic           hour_par;
  logic           date_par;

  always_comb begin
    year_bcd = dcf_pkg::bcd_small(in_stg.year_rem);
    min_par  = ^in_stg.min_bcd;
    hour_par = ^in_stg.hour_bcd;
    date_par = ^{year_bcd, in_stg.mon_bcd, in_stg.wday_bcd, in_stg.day_bcd};

    // second 0 sits at the right end
    stg3_nxt.frame = {1'b0, date_par, year_bcd, in_stg.mon_bcd, in_stg.wday_bcd,
                      in_stg.day_bcd, hour_par, in_stg.hour_bcd, min_par,
                      in_stg.min_bcd, 1'b1, 1'b0, ~in_stg.summer, in_stg.summer,
                      17'b0};
    stg3_nxt.sec   = in_stg.sec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg3_r <= stg3_nxt;
    end
  end

endmodule

FILE: rtl/dcf_tap.sv
`timescale 1ns / 1ps

module dcf_tap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  dcf_pkg::stg3_t                in_stg,
  output logic                          vld_r,
  output logic [dcf_pkg::FrameBits-1:0] frame_r,
  output logic                          bit_r
);

  logic bit_nxt;

  assign bit_nxt = in_stg.frame[in_stg.sec];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_r <= in_stg.frame;
      bit_r   <= bit_nxt;
    end
  end

endmodule

FILE: rtl/dcf77_frame_encoder.sv
`timescale 1ns / 1ps

// channel | valid    | stall     | payload
// --------+----------+-----------+--------------------------------------------
// input   | in_valid | in_stall  | in_minute .. in_second_index
// result  | out_valid| out_stall | out_frame, out_second_bit
//
// Four register stages: digit split and year quotient, year remainder,
// frame assembly with parity, second tap. One transfer per cycle is
// sustained while no result is held under out_stall.
// rst_n (synchronous) clears the stage valid bits; payload is not reset.
// A held result under out_stall freezes every stage and raises in_stall.
module dcf77_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_minute,
  input  logic [4:0]  in_hour,
  input  logic [4:0]  in_day_of_month,
  input  logic [2:0]  in_day_of_week,
  input  logic [3:0]  in_month_number,
  input  logic [13:0] in_full_year,
  input  logic        in_summer_time,
  input  logic [5:0]  in_second_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [59:0] out_frame,
  output logic        out_second_bit
);

  logic             adv;
  dcf_pkg::fields_t fld;
  logic             vld2;
  dcf_pkg::stg2_t   stg2;
  logic             vld3;
  dcf_pkg::stg3_t   stg3;

  // advance the whole pipe unless a result is waiting
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    fld.minute       = in_minute;
    fld.hour         = in_hour;
    fld.day_of_month = in_day_of_month;
    fld.day_of_week  = in_day_of_week;
    fld.month_number = in_month_number;
    fld.full_year    = in_full_year;
    fld.summer_time  = in_summer_time;
    fld.second_index = in_second_index;
  end

  dcf_split u_split (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (in_valid),
    .in_fld (fld),
    .vld_r  (vld2),
    .stg2_r (stg2)
  );

  dcf_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .in_vld (vld2),
    .in_stg (stg2),
    .vld_r  (vld3),
    .stg3_r (stg3)
  );

  dcf_tap u_tap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (vld3),
    .in_stg  (stg3),
    .vld_r   (out_valid),
    .frame_r (out_frame),
    .bit_r   (out_second_bit)
  );

  a_fixed_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame[20] && !out_frame[59] && !out_frame[19] &&
                   (out_frame[17] != out_frame[18]) && (out_frame[16:0] == 17'b0)))
    else $error("fixed frame marks wrong");

  a_time_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((^out_frame[28:21]) == 1'b0 && (^out_frame[35:29]) == 1'b0))
    else $error("minute or hour parity wrong");

  a_date_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((^out_frame[58:36]) == 1'b0))
    else $error("date parity wrong");

  a_year_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame[57:54] <= 4'd9 && out_frame[53:50] <= 4'd9))
    else $error("year digits out of range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame) &&
                                  $stable(out_second_bit)))
    else $error("held result changed");

endmodule
